@@ sv/tfsk_pkg.sv @@
// Shared types, register indexes and sine table builder for the two-tone FSK generator.
// No dependencies; every other file of the block except tfsk_queue imports this package.
`default_nettype none

package tfsk_pkg;

  // Configuration port layout
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CFG_PHASE_STEP_LOW  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_PHASE_STEP_HIGH = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_TONE_LENGTH     = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_BLOCKS_PER_PKT  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_AMPLITUDE       = 3'd4;

  // Register reset values
  localparam logic [15:0] TONE_LENGTH_RST = 16'd64;
  localparam logic [15:0] BLOCKS_PER_PKT_RST = 16'd1;
  localparam logic [14:0] AMPLITUDE_RST = 15'd32767;

  // Q30 Taylor coefficients of sin(pi/2 * x)
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  // Configuration registers as seen by the front and back
  typedef struct packed {
    logic [31:0] phase_step_low;
    logic [31:0] phase_step_high;
    logic [15:0] tone_length;
    logic [15:0] blocks_per_packet;
    logic [14:0] amplitude;
  } cfg_t;

  // Per-sample flags carried from front to back
  typedef struct packed {
    logic packet_start;
    logic tone_is_high;
  } flags_t;

  // Build one signed sine table entry, sign-extended to 32 bits
  function automatic logic [31:0] sine_entry(input int unsigned k,
                                             input int unsigned tab_bits,
                                             input int unsigned sample_bits);
    logic [63:0] quarter;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] pos;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] smax;
    logic [63:0] m;
    quarter = 64'd1 << (tab_bits - 2);
    quad    = 64'(k) >> (tab_bits - 2);
    r       = 64'(k) & (quarter - 64'd1);
    pos     = quad[0] ? (quarter - r) : r;
    x       = pos << (30 - (tab_bits - 2));
    x2      = (x * x) >> 30;
    t       = C9;
    t       = C7 - ((x2 * t) >> 30);
    t       = C5 - ((x2 * t) >> 30);
    t       = C3 - ((x2 * t) >> 30);
    t       = C1 - ((x2 * t) >> 30);
    p       = (x * t) >> 30;
    smax    = (64'd1 << (sample_bits - 1)) - 64'd1;
    m       = (p * smax + (64'd1 << 29)) >> 30;
    if (m > smax) begin
      m = smax;
    end
    return quad[1] ? 32'(64'd0 - m) : 32'(m);
  endfunction

endpackage

`default_nettype wire

@@ sv/two_tone_fsk_nco_generator.sv @@
// Two-tone FSK generator top level: configuration registers, front, queue and back.
// Depends on tfsk_pkg, tfsk_front, tfsk_queue and tfsk_back.
//
// Usage:
//   Input side is a queue: drive sample_request_i and push; a word is taken
//   when push is high and full is low. A word with sample_request_i low is
//   taken and dropped with no state change; a word with it high yields one
//   complex sample. Results come out as a queue: the oldest sample sits on
//   i_sample_o, q_sample_o, packet_start_o and tone_is_high_o while empty is
//   low and is taken when pop is high.
//   An accepted sample passes through the front queue, the registered table
//   read and the registered amplitude scaling, then lands in the result queue.
//   Throughput is one sample per cycle while the receiver keeps popping, set
//   by the phase and counter update in the front.
//   When the receiver stalls, the back stops pulling once queued and in-flight
//   samples (the two pipeline stages count too) fill the 4-deep result queue;
//   the 2-deep front queue then fills and full rises. Nothing is dropped.
//   Reset clears phases and counters, selects the high tone so the first
//   sample swaps to low, and loads the register defaults. Configuration words
//   on cfg_valid_i are always taken and should be written while idle.
`default_nettype none

module two_tone_fsk_nco_generator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [tfsk_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [tfsk_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  wire logic                                push,
  output      logic                                full,
  input  wire logic                                sample_request_i,
  input  wire logic                                pop,
  output      logic                                empty,
  output      logic signed [SAMPLE_BITS-1:0]       i_sample_o,
  output      logic signed [SAMPLE_BITS-1:0]       q_sample_o,
  output      logic                                packet_start_o,
  output      logic                                tone_is_high_o
);

  import tfsk_pkg::*;

  localparam int unsigned MidWidth = TABLE_ADDR_BITS + $bits(flags_t);

  cfg_t                       cfg_q, cfg_d;
  logic                       emit;
  logic [TABLE_ADDR_BITS-1:0] front_addr;
  flags_t                     front_flags;
  logic [MidWidth-1:0]        mid_rdata;
  logic                       mid_empty;
  logic                       mid_pop;
  logic [1:0]                 mid_count;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PHASE_STEP_LOW:  cfg_d.phase_step_low    = cfg_data_i;
        CFG_PHASE_STEP_HIGH: cfg_d.phase_step_high   = cfg_data_i;
        CFG_TONE_LENGTH:     cfg_d.tone_length       = cfg_data_i[15:0];
        CFG_BLOCKS_PER_PKT:  cfg_d.blocks_per_packet = cfg_data_i[15:0];
        CFG_AMPLITUDE:       cfg_d.amplitude         = cfg_data_i[14:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step_low    <= '0;
      cfg_q.phase_step_high   <= '0;
      cfg_q.tone_length       <= TONE_LENGTH_RST;
      cfg_q.blocks_per_packet <= BLOCKS_PER_PKT_RST;
      cfg_q.amplitude         <= AMPLITUDE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tfsk_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (push && !full),
    .sample_request_i (sample_request_i),
    .emit_o           (emit),
    .addr_o           (front_addr),
    .flags_o          (front_flags)
  );

  tfsk_queue #(
    .WIDTH (MidWidth),
    .DEPTH (2)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .wdata_i ({front_addr, front_flags}),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  tfsk_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .amplitude_i    (cfg_q.amplitude),
    .mid_empty_i    (mid_empty || (mid_count == 2'd0)),
    .mid_addr_i     (mid_rdata[MidWidth-1 -: TABLE_ADDR_BITS]),
    .mid_flags_i    (mid_rdata[$bits(flags_t)-1:0]),
    .mid_pop_o      (mid_pop),
    .pop            (pop),
    .empty          (empty),
    .i_sample_o     (i_sample_o),
    .q_sample_o     (q_sample_o),
    .packet_start_o (packet_start_o),
    .tone_is_high_o (tone_is_high_o)
  );

endmodule

`default_nettype wire

@@ sv/tfsk_queue.sv @@
// Small first-in first-out buffer with a fill count.
// Uses no package; instantiated between front and back and at the result side.
`default_nettype none

module tfsk_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  output      logic                         full_o,
  input  wire logic                         pop_i,
  output      logic [WIDTH-1:0]             rdata_o,
  output      logic                         empty_o,
  output      logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/tfsk_front.sv @@
// Front end: takes request words, runs both phase accumulators and the tone counters.
// Depends on tfsk_pkg; emits a table address and flags per produced sample.
`default_nettype none

module tfsk_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tfsk_pkg::cfg_t             cfg_i,
  input  wire logic                       accept_i,
  input  wire logic                       sample_request_i,
  output      logic                       emit_o,
  output      logic [TABLE_ADDR_BITS-1:0] addr_o,
  output      tfsk_pkg::flags_t           flags_o
);

  import tfsk_pkg::*;

  logic [PHASE_BITS-1:0] low_phase_q, low_phase_d;
  logic [PHASE_BITS-1:0] high_phase_q, high_phase_d;
  logic                  tone_sel_q, tone_sel_d;
  logic [15:0]           tone_cnt_q, tone_cnt_d;
  logic [16:0]           seg_cnt_q, seg_cnt_d;

  logic [15:0]           len_eff;
  logic [15:0]           bpp_eff;
  logic                  tone_wrap;
  logic                  seg_wrap;
  logic                  tone_sel_now;
  logic [PHASE_BITS-1:0] active_phase;

  // Classify: only a word with a request produces a sample
  assign emit_o = accept_i && sample_request_i;

  assign len_eff      = (cfg_i.tone_length == '0) ? 16'd1 : cfg_i.tone_length;
  assign bpp_eff      = (cfg_i.blocks_per_packet == '0) ? 16'd1 : cfg_i.blocks_per_packet;
  assign tone_wrap    = (({1'b0, tone_cnt_q} + 17'd1) >= {1'b0, len_eff});
  assign seg_wrap     = (({1'b0, seg_cnt_q} + 18'd1) >= {1'b0, bpp_eff, 1'b0});
  assign tone_sel_now = (tone_cnt_q == '0) ? ~tone_sel_q : tone_sel_q;
  assign active_phase = tone_sel_now ? high_phase_q : low_phase_q;

  assign addr_o               = active_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign flags_o.packet_start = (tone_cnt_q == '0) && (seg_cnt_q == '0);
  assign flags_o.tone_is_high = tone_sel_now;

  // Step accumulators and counters once per produced sample
  always_comb begin
    low_phase_d  = low_phase_q;
    high_phase_d = high_phase_q;
    tone_sel_d   = tone_sel_q;
    tone_cnt_d   = tone_cnt_q;
    seg_cnt_d    = seg_cnt_q;
    if (emit_o) begin
      low_phase_d  = low_phase_q + PHASE_BITS'(cfg_i.phase_step_low);
      high_phase_d = high_phase_q + PHASE_BITS'(cfg_i.phase_step_high);
      tone_sel_d   = tone_sel_now;
      if (tone_wrap) begin
        tone_cnt_d = '0;
        seg_cnt_d  = seg_wrap ? 17'd0 : seg_cnt_q + 17'd1;
      end else begin
        tone_cnt_d = tone_cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_phase_q  <= '0;
      high_phase_q <= '0;
      tone_sel_q   <= 1'b1;
      tone_cnt_q   <= '0;
      seg_cnt_q    <= '0;
    end else begin
      low_phase_q  <= low_phase_d;
      high_phase_q <= high_phase_d;
      tone_sel_q   <= tone_sel_d;
      tone_cnt_q   <= tone_cnt_d;
      seg_cnt_q    <= seg_cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/tfsk_back.sv @@
// Back end: sine table lookup, amplitude scaling and the result queue.
// Depends on tfsk_pkg and tfsk_queue; pulls words from the front queue on credit.
`default_nettype none

module tfsk_back #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [14:0]                   amplitude_i,
  input  wire logic                          mid_empty_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]    mid_addr_i,
  input  wire tfsk_pkg::flags_t              mid_flags_i,
  output      logic                          mid_pop_o,
  input  wire logic                          pop,
  output      logic                          empty,
  output      logic signed [SAMPLE_BITS-1:0] i_sample_o,
  output      logic signed [SAMPLE_BITS-1:0] q_sample_o,
  output      logic                          packet_start_o,
  output      logic                          tone_is_high_o
);

  import tfsk_pkg::*;

  localparam int unsigned TblSize = 1 << TABLE_ADDR_BITS;
  localparam int unsigned Quarter = 1 << (TABLE_ADDR_BITS - 2);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutCw = $clog2(OutDepth + 1);
  localparam int unsigned MagBits = SAMPLE_BITS - 1;
  localparam int unsigned ProdBits = MagBits + 16;
  localparam int unsigned OutWidth = 2 * SAMPLE_BITS + $bits(flags_t);

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [TblSize];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < TblSize; k++) begin
      rom[k] = SAMPLE_BITS'(sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                          v1_q, v2_q;
  flags_t                        flags1_q, flags2_q;
  logic signed [SAMPLE_BITS-1:0] sin_q, cos_q;
  logic signed [SAMPLE_BITS-1:0] i_q, q_q;
  logic [TABLE_ADDR_BITS-1:0]    cos_addr;
  logic [OutCw-1:0]              out_count;
  logic                          out_full;
  logic [OutWidth-1:0]           out_word;
  logic [OutWidth-1:0]           out_rdata;
  flags_t                        out_flags;

  // Issue only when the result queue has room for everything in flight
  assign mid_pop_o = !mid_empty_i &&
                     ((OutCw + 1)'(out_count) + (OutCw + 1)'(v1_q) + (OutCw + 1)'(v2_q)
                      < (OutCw + 1)'(OutDepth));

  assign cos_addr = mid_addr_i + TABLE_ADDR_BITS'(Quarter);

  // Round amplitude times the magnitude, ties away from zero, then restore sign
  function automatic logic signed [SAMPLE_BITS-1:0] scale(
      input logic signed [SAMPLE_BITS-1:0] t, input logic [14:0] amp);
    logic [SAMPLE_BITS-1:0] neg_t;
    logic [MagBits-1:0]     mag;
    logic [ProdBits-1:0]    prod;
    logic [SAMPLE_BITS-1:0] s;
    neg_t = SAMPLE_BITS'(-t);
    mag   = t[SAMPLE_BITS-1] ? neg_t[MagBits-1:0] : t[MagBits-1:0];
    prod  = ProdBits'(amp) * ProdBits'(mag) + ProdBits'(1 << 14);
    s     = prod[ProdBits-1:15];
    return t[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : s;
  endfunction

  // Hold pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= mid_pop_o;
      v2_q <= v1_q;
    end
  end

  // Read the table, then scale both components
  always_ff @(posedge clk_i) begin
    sin_q    <= SINE_ROM[mid_addr_i];
    cos_q    <= SINE_ROM[cos_addr];
    flags1_q <= mid_flags_i;
    i_q      <= scale(cos_q, amplitude_i);
    q_q      <= scale(sin_q, amplitude_i);
    flags2_q <= flags1_q;
  end

  assign out_word = {i_q, q_q, flags2_q};

  tfsk_queue #(
    .WIDTH (OutWidth),
    .DEPTH (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v2_q),
    .wdata_i (out_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_flags      = out_rdata[$bits(flags_t)-1:0];
  assign i_sample_o     = out_rdata[OutWidth-1 -: SAMPLE_BITS];
  assign q_sample_o     = out_rdata[$bits(flags_t) +: SAMPLE_BITS];
  assign packet_start_o = out_flags.packet_start && !out_full | out_flags.packet_start;
  assign tone_is_high_o = out_flags.tone_is_high;

endmodule

`default_nettype wire

@@ dv/tfsk_sample_checker.sv @@
// Sample checker for the two-tone FSK generator: predicts every sample word and
// compares it against the result queue. Depends on tfsk_pkg for register indexes.
// Hands its mismatch count and the number of outstanding samples to the test top.

module tfsk_sample_checker #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_i,
  input  wire logic [tfsk_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [tfsk_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                             push_i,
  input  wire logic                             full_i,
  input  wire logic                             sample_request_i,
  input  wire logic                             pop_i,
  input  wire logic                             empty_i,
  input  wire logic [SAMPLE_BITS-1:0]           i_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]           q_sample_i,
  input  wire logic                             packet_start_i,
  input  wire logic                             tone_is_high_i,
  output int                                    mismatches_o,
  output int                                    pending_o
);

  import tfsk_pkg::*;

  localparam int unsigned LUT_SIZE    = 1 << TABLE_ADDR_BITS;
  localparam int unsigned LUT_QUARTER = 1 << (TABLE_ADDR_BITS - 2);

  // Q30 odd Taylor terms of sin(pi/2 * x)
  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598668;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026995;
  localparam logic [63:0] SIN_K9 = 64'd172272;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] i_val;
    logic [SAMPLE_BITS-1:0] q_val;
    logic                   start;
    logic                   high;
  } sample_t;

  // Register copies
  logic [PHASE_BITS-1:0] step_low;
  logic [PHASE_BITS-1:0] step_high;
  logic [15:0]           seg_len;
  logic [15:0]           pair_count;
  logic [14:0]           gain;

  // Generator state copies
  logic [PHASE_BITS-1:0] low_acc;
  logic [PHASE_BITS-1:0] high_acc;
  logic                  on_high;
  logic [15:0]           tone_pos;
  logic [16:0]           seg_pos;

  int      sine_lut [LUT_SIZE];
  sample_t samples_due [$];
  int      mismatch_count  = 0;
  int      pending_count   = 0;
  int      samples_checked = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  // Evaluate the quarter-wave polynomial in Q30 with truncating shifts
  function automatic logic [63:0] sin_quarter_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    x2  = (x * x) >> 30;
    acc = SIN_K9;
    acc = SIN_K7 - ((x2 * acc) >> 30);
    acc = SIN_K5 - ((x2 * acc) >> 30);
    acc = SIN_K3 - ((x2 * acc) >> 30);
    acc = SIN_K1 - ((x2 * acc) >> 30);
    return (x * acc) >> 30;
  endfunction

  // Scale a table value by the Q0.15 gain, ties away from zero
  function automatic logic [SAMPLE_BITS-1:0] scaled(input int entry, input logic [14:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (entry < 0) ? 64'(-entry) : 64'(entry);
    prod = (64'(g) * mag + 64'd16384) >> 15;
    return (entry < 0) ? SAMPLE_BITS'(64'd0 - prod) : SAMPLE_BITS'(prod);
  endfunction

  // Produce one sample from the active tone and advance both accumulators
  function automatic sample_t synth_sample();
    sample_t                    s;
    int unsigned                len;
    int unsigned                segs;
    logic [PHASE_BITS-1:0]      ph;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [TABLE_ADDR_BITS-1:0] cos_addr;
    len     = (seg_len == 0) ? 1 : seg_len;
    segs    = 2 * ((pair_count == 0) ? 1 : pair_count);
    s.start = (tone_pos == 0) && (seg_pos == 0);
    if (tone_pos == 0) begin
      on_high = ~on_high;
    end
    ph       = on_high ? high_acc : low_acc;
    addr     = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    cos_addr = addr + TABLE_ADDR_BITS'(LUT_QUARTER);
    s.i_val  = scaled(sine_lut[cos_addr], gain);
    s.q_val  = scaled(sine_lut[addr], gain);
    s.high   = on_high;
    low_acc  = low_acc + step_low;
    high_acc = high_acc + step_high;
    if (32'(tone_pos) + 1 >= len) begin
      tone_pos = '0;
      seg_pos  = (32'(seg_pos) + 1 >= segs) ? '0 : seg_pos + 17'd1;
    end else begin
      tone_pos = tone_pos + 16'd1;
    end
    return s;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Fill the sine table, sign set by quadrant
  initial begin : build_lut
    int unsigned quad;
    int unsigned r;
    logic [63:0] pos;
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] full_scale;
    full_scale = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int unsigned k = 0; k < LUT_SIZE; k++) begin
      quad = k >> (TABLE_ADDR_BITS - 2);
      r    = k & (LUT_QUARTER - 1);
      pos  = quad[0] ? 64'(LUT_QUARTER - r) : 64'(r);
      p    = sin_quarter_q30(pos << (30 - (TABLE_ADDR_BITS - 2)));
      m    = (p * full_scale + (64'd1 << 29)) >> 30;
      if (m > full_scale) begin
        m = full_scale;
      end
      sine_lut[k] = quad[1] ? -int'(m) : int'(m);
    end
  end

  // Watch the three channels; compare before queuing so a new word never pairs up early
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      step_low   = '0;
      step_high  = '0;
      seg_len    = TONE_LENGTH_RST;
      pair_count = BLOCKS_PER_PKT_RST;
      gain       = AMPLITUDE_RST;
      low_acc    = '0;
      high_acc   = '0;
      on_high    = 1'b1;
      tone_pos   = '0;
      seg_pos    = '0;
      samples_due.delete();
      pending_count <= 0;
    end else begin
      // Check the word leaving the result queue
      if (pop_i && !empty_i) begin
        samples_checked++;
        if (samples_due.size() == 0) begin
          flag_mismatch($sformatf("sample %0d arrived with nothing expected", samples_checked));
        end else begin
          want = samples_due.pop_front();
          if (i_sample_i !== want.i_val) begin
            flag_mismatch($sformatf("sample %0d i_sample: got %0d, want %0d", samples_checked,
                                    $signed(i_sample_i), $signed(want.i_val)));
          end
          if (q_sample_i !== want.q_val) begin
            flag_mismatch($sformatf("sample %0d q_sample: got %0d, want %0d", samples_checked,
                                    $signed(q_sample_i), $signed(want.q_val)));
          end
          if (packet_start_i !== want.start) begin
            flag_mismatch($sformatf("sample %0d packet_start: got %b, want %b",
                                    samples_checked, packet_start_i, want.start));
          end
          if (tone_is_high_i !== want.high) begin
            flag_mismatch($sformatf("sample %0d tone_is_high: got %b, want %b",
                                    samples_checked, tone_is_high_i, want.high));
          end
        end
      end
      // Track register writes; unmapped indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PHASE_STEP_LOW:  step_low   = PHASE_BITS'(cfg_data_i);
          CFG_PHASE_STEP_HIGH: step_high  = PHASE_BITS'(cfg_data_i);
          CFG_TONE_LENGTH:     seg_len    = cfg_data_i[15:0];
          CFG_BLOCKS_PER_PKT:  pair_count = cfg_data_i[15:0];
          CFG_AMPLITUDE:       gain       = cfg_data_i[14:0];
          default: ;
        endcase
      end
      // Predict a sample for every accepted request word
      if (push_i && !full_i && sample_request_i) begin
        samples_due.push_back(synth_sample());
      end
      pending_count <= samples_due.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Test top for the two-tone FSK generator: clock, reset, register settings,
// request words and result draining, plus the final verdict.
// Depends on tfsk_pkg, two_tone_fsk_nco_generator and tfsk_sample_checker.

module tb;
  import tfsk_pkg::*;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_WORDS  = 1600;
  localparam int unsigned REQUEST_PCT   = 85;

  localparam logic [CfgIdxBits-1:0] CFG_UNMAPPED = CfgIdxBits'(7);

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_valid_i      = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i      = '0;
  logic [CfgDataBits-1:0] cfg_data_i       = '0;
  logic                   push             = 1'b0;
  logic                   full;
  logic                   sample_request_i = 1'b0;
  logic                   pop              = 1'b0;
  logic                   empty;
  logic [SAMPLE_BITS-1:0] i_sample_o;
  logic [SAMPLE_BITS-1:0] q_sample_o;
  logic                   packet_start_o;
  logic                   tone_is_high_o;

  int   mismatches;
  int   pending;
  int   words_sent    = 0;
  int   requests_sent = 0;
  int   settings_used = 0;
  logic calm_push     = 1'b0;
  logic calm_pop      = 1'b0;

  always #5 clk_i = ~clk_i;

  two_tone_fsk_nco_generator #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .sample_request_i(sample_request_i),
    .pop             (pop),
    .empty           (empty),
    .i_sample_o      (i_sample_o),
    .q_sample_o      (q_sample_o),
    .packet_start_o  (packet_start_o),
    .tone_is_high_o  (tone_is_high_o)
  );

  tfsk_sample_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push),
    .full_i          (full),
    .sample_request_i(sample_request_i),
    .pop_i           (pop),
    .empty_i         (empty),
    .i_sample_i      (i_sample_o),
    .q_sample_i      (q_sample_o),
    .packet_start_i  (packet_start_o),
    .tone_is_high_i  (tone_is_high_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Offer one word, first idling at random unless in a calm stretch
  task automatic send_word(input logic req);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      calm_push = ~calm_push;
    end
    gap = calm_push ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    sample_request_i <= req;
    do @(posedge clk_i); while (full);
    words_sent++;
    if (req) begin
      requests_sent++;
    end
  endtask

  // Write one register and drop valid for a cycle
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every predicted sample is out and dropped words have drained
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'd1;
      4, 5:    return 32'($urandom_range(0, 1 << 24));
      default: return $urandom;
    endcase
  endfunction

  // Mostly short counts so swaps and packet starts show up; junk in the upper bits
  function automatic logic [31:0] pick_count(input int unsigned typical_max);
    logic [15:0] cnt;
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = '1;
      2:       cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(1, typical_max));
    endcase
    return {16'($urandom), cnt};
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h0000_7FFF;
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Rewrite a random subset of registers; counters carry over on purpose
  task automatic draw_settings();
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PHASE_STEP_LOW, pick_step());
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PHASE_STEP_HIGH, pick_step());
    if ($urandom_range(0, 2) != 0) write_reg(CFG_TONE_LENGTH, pick_count(24));
    if ($urandom_range(0, 2) != 0) write_reg(CFG_BLOCKS_PER_PKT, pick_count(4));
    if ($urandom_range(0, 2) != 0) write_reg(CFG_AMPLITUDE, pick_gain());
    settings_used++;
  endtask

  // Drain results with random stalls
  initial begin : drain
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        calm_pop = ~calm_pop;
      end
      gap = calm_pop ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    int n;
    int rand_words;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, including a dropped word
    settings_used = 1;
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    wait_idle();

    // Zero tone length and zero blocks, widest step, gain masked from all ones
    write_reg(CFG_PHASE_STEP_LOW, 32'h0123_4567);
    write_reg(CFG_PHASE_STEP_HIGH, '1);
    write_reg(CFG_TONE_LENGTH, '0);
    write_reg(CFG_BLOCKS_PER_PKT, '0);
    write_reg(CFG_AMPLITUDE, '1);
    write_reg(CFG_UNMAPPED, '1);
    settings_used++;
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    wait_idle();

    // Short segments with junk in the upper data bits, zero gain
    write_reg(CFG_TONE_LENGTH, 32'hABCD_0003);
    write_reg(CFG_BLOCKS_PER_PKT, 32'h5A5A_0003);
    write_reg(CFG_AMPLITUDE, '0);
    settings_used++;
    repeat (5) send_word(1'b1);
    wait_idle();

    // Shrink the bounds below the running counters
    write_reg(CFG_TONE_LENGTH, 32'd1);
    write_reg(CFG_BLOCKS_PER_PKT, 32'd1);
    write_reg(CFG_AMPLITUDE, 32'd1);
    write_reg(CFG_PHASE_STEP_LOW, 32'h8000_0000);
    write_reg(CFG_PHASE_STEP_HIGH, 32'd1);
    settings_used++;
    repeat (4) send_word(1'b1);
    wait_idle();

    // Largest bounds, half gain
    write_reg(CFG_TONE_LENGTH, 32'h0000_FFFF);
    write_reg(CFG_BLOCKS_PER_PKT, 32'h0000_FFFF);
    write_reg(CFG_AMPLITUDE, 32'd16384);
    write_reg(CFG_PHASE_STEP_LOW, 32'h4000_0000);
    settings_used++;
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);

    // Random phases: new settings, then a run of mostly request words
    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      wait_idle();
      draw_settings();
      n = $urandom_range(40, 160);
      repeat (n) send_word($urandom_range(0, 99) < REQUEST_PCT);
      rand_words += n;
    end
    wait_idle();

    $display("covered %0d words (%0d sample requests) across %0d register settings",
             words_sent, requests_sent, settings_used);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("watchdog expired with %0d samples outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
